// File: src/rep_pkg.sv
// ----------------------------------------------------------------------------
// rep_pkg: shared constants and CORDIC helpers for the ray end point generator
// Holds the angle constants, the arctangent table and one rotation step.
// ----------------------------------------------------------------------------
package rep_pkg;

  localparam int ANG_W          = 17;
  localparam int CORD_STEPS     = 30;
  localparam int CORD_PER_STAGE = 2;
  localparam int CORD_STAGES    = CORD_STEPS / CORD_PER_STAGE;
  localparam int CORD_LAT       = CORD_STAGES + 2;

  // quarter turn and half of it in 2^-30 rad
  localparam logic signed [34:0] HALF_PI  = 35'sd1686629713;
  localparam logic signed [34:0] QTR_HALF = 35'sd843314856;
  localparam logic signed [32:0] CORD_GAIN = 33'sd652032874;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_PITCH  = 3'd0;
  localparam logic [2:0] CFG_PITCH_STEP = 3'd1;
  localparam logic [2:0] CFG_MAX_PITCH  = 3'd2;
  localparam logic [2:0] CFG_MIN_YAW    = 3'd3;
  localparam logic [2:0] CFG_YAW_STEP   = 3'd4;
  localparam logic [2:0] CFG_MAX_YAW    = 3'd5;
  localparam logic [2:0] CFG_MAX_RANGE  = 3'd6;

  typedef logic signed [32:0] cord_t;

  typedef struct packed {
    cord_t x;
    cord_t y;
    cord_t z;
  } rot_t;

  localparam logic [29:0] ATAN_TAB [CORD_STEPS] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001
  };

  // one rotation-mode iteration; shifts round toward minus infinity
  function automatic rot_t rot_step(rot_t a, int unsigned i);
    rot_t  b;
    cord_t dx;
    cord_t dy;
    cord_t da;
    dx = a.y >>> i;
    dy = a.x >>> i;
    da = cord_t'({3'b000, ATAN_TAB[i]});
    if (!a.z[32]) begin
      b.x = a.x - dx;
      b.y = a.y + dy;
      b.z = a.z - da;
    end else begin
      b.x = a.x + dx;
      b.y = a.y - dy;
      b.z = a.z + da;
    end
    return b;
  endfunction

endpackage

// File: src/rep_cordic.sv
// ----------------------------------------------------------------------------
// rep_cordic: pipelined sine and cosine of one angle
// Quadrant reduction, fifteen stages of two CORDIC iterations, quadrant fixup.
// ----------------------------------------------------------------------------
module rep_cordic import rep_pkg::*; (
  input  logic                     clk,
  input  logic signed [ANG_W-1:0]  ang,
  output logic signed [31:0]       cos_v,
  output logic signed [31:0]       sin_v
);

  logic signed [34:0] a_w;
  logic signed [34:0] ap_w;
  logic [3:0]         cnt_w;
  logic signed [4:0]  m_w;
  logic signed [34:0] z_w;

  rot_t       rot_r  [CORD_STAGES+1];
  logic [1:0] quad_r [CORD_STAGES+1];
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;

  assign a_w  = 35'(ang) <<< 17;
  assign ap_w = a_w + QTR_HALF;

  // count quarter-turn thresholds passed; quadrant index lands in -5..5
  always_comb begin
    cnt_w = 4'd0;
    for (int j = -4; j <= 5; j++) begin
      if (ap_w >= HALF_PI * 35'(j)) cnt_w = cnt_w + 4'd1;
    end
  end

  assign m_w = $signed({1'b0, cnt_w}) - 5'sd5;
  assign z_w = a_w - HALF_PI * 35'(m_w);

  always_ff @(posedge clk) begin
    rot_r[0].x <= CORD_GAIN;
    rot_r[0].y <= '0;
    rot_r[0].z <= 33'(z_w);
    quad_r[0]  <= m_w[1:0];
  end

  for (genvar g = 0; g < CORD_STAGES; g++) begin : g_stage
    always_ff @(posedge clk) begin
      rot_r[g+1]  <= rot_step(rot_step(rot_r[g], CORD_PER_STAGE * g),
                              CORD_PER_STAGE * g + 1);
      quad_r[g+1] <= quad_r[g];
    end
  end

  always_ff @(posedge clk) begin
    unique case (quad_r[CORD_STAGES])
      2'd0: begin
        cos_r <= 32'(rot_r[CORD_STAGES].x);
        sin_r <= 32'(rot_r[CORD_STAGES].y);
      end
      2'd1: begin
        cos_r <= 32'(-rot_r[CORD_STAGES].y);
        sin_r <= 32'(rot_r[CORD_STAGES].x);
      end
      2'd2: begin
        cos_r <= 32'(-rot_r[CORD_STAGES].x);
        sin_r <= 32'(-rot_r[CORD_STAGES].y);
      end
      default: begin
        cos_r <= 32'(rot_r[CORD_STAGES].y);
        sin_r <= 32'(-rot_r[CORD_STAGES].x);
      end
    endcase
  end

  assign cos_v = cos_r;
  assign sin_v = sin_r;

endmodule

// File: src/rep_scale.sv
// ----------------------------------------------------------------------------
// rep_scale: scale a unit component by 1.1 * range, round, saturate
// Four register stages: range product, times 11 and coarse shift, reciprocal
// multiply for the divide by ten, sign and clamp.
// ----------------------------------------------------------------------------
module rep_scale import rep_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] v,
  input  logic [15:0]        range,
  output logic signed [17:0] end_v
);

  localparam logic [19:0] RECIP10 = 20'd838861;  // ceil(2^23 / 10)

  logic signed [48:0] prod_r;
  logic signed [51:0] p11_w;
  logic [51:0]        mag_w;
  logic [51:0]        sum_w;
  logic [21:0]        q1_w;
  logic [20:0]        q1_r;
  logic               neg1_r;
  logic [40:0]        qm_r;
  logic               neg2_r;
  logic [17:0]        q_w;
  logic signed [18:0] sv_w;
  logic signed [17:0] end_r;

  always_ff @(posedge clk) begin
    prod_r <= 49'(v) * 49'($signed({1'b0, range}));
  end

  assign p11_w = (52'(prod_r) <<< 3) + (52'(prod_r) <<< 1) + 52'(prod_r);
  assign mag_w = p11_w[51] ? 52'(-p11_w) : 52'(p11_w);
  assign sum_w = mag_w + 52'd5368709120;
  assign q1_w  = 22'(sum_w >> 30);

  // hold the quotient input within 21 bits; anything larger clamps anyway
  always_ff @(posedge clk) begin
    q1_r   <= q1_w[21] ? '1 : q1_w[20:0];
    neg1_r <= p11_w[51];
  end

  always_ff @(posedge clk) begin
    qm_r   <= 41'(q1_r) * 41'(RECIP10);
    neg2_r <= neg1_r;
  end

  assign q_w  = qm_r[40:23];
  assign sv_w = neg2_r ? -$signed({1'b0, q_w}) : $signed({1'b0, q_w});

  always_ff @(posedge clk) begin
    if (sv_w > 19'sd131071)       end_r <= 18'sd131071;
    else if (sv_w < -19'sd131072) end_r <= -18'sd131072;
    else                          end_r <= 18'(sv_w);
  end

  assign end_v = end_r;

endmodule

// File: src/ray_endpoint_generator.sv
// ----------------------------------------------------------------------------
// ray_endpoint_generator: Cartesian end point of one scan grid ray
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the angle register, the 15-stage CORDIC pipeline, the
// direction product and rounding registers and the range and scale stages.
// Reset: synchronous, active low; clears valid bits and loads register defaults.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module ray_endpoint_generator import rep_pkg::*; #(
  parameter int PITCH_ROWS  = 16,
  parameter int YAW_COLUMNS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_row,
  input  logic [5:0]         in_column,
  output logic               out_valid,
  output logic signed [17:0] out_end_x,
  output logic signed [17:0] out_end_y,
  output logic signed [17:0] out_end_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  localparam int LAT = CORD_LAT + 7;

  // configuration registers
  logic signed [16:0] min_pitch_r, max_pitch_r, min_yaw_r, max_yaw_r;
  logic [15:0]        pitch_step_r, yaw_step_r, range_lim_r;

  logic               req_w;
  logic [LAT-1:0]     vld_r;

  logic signed [21:0] pitch_sum_w;
  logic signed [23:0] yaw_sum_w;
  logic signed [16:0] pitch_nxt, yaw_nxt;
  logic signed [16:0] pitch_r, yaw_r;

  logic signed [31:0] cp_w, sp_w, cy_w, sy_w;
  logic signed [63:0] pxx_r, pxy_r;
  logic signed [31:0] sp1_r;
  logic signed [31:0] ux_r, uy_r, uz_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign req_w     = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pitch_r  <= '0;
      pitch_step_r <= '0;
      max_pitch_r  <= '0;
      min_yaw_r    <= '0;
      yaw_step_r   <= '0;
      max_yaw_r    <= '0;
      range_lim_r  <= 16'd2560;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_PITCH:  min_pitch_r  <= $signed(cfg_data);
        CFG_PITCH_STEP: pitch_step_r <= cfg_data[15:0];
        CFG_MAX_PITCH:  max_pitch_r  <= $signed(cfg_data);
        CFG_MIN_YAW:    min_yaw_r    <= $signed(cfg_data);
        CFG_YAW_STEP:   yaw_step_r   <= cfg_data[15:0];
        CFG_MAX_YAW:    max_yaw_r    <= $signed(cfg_data);
        CFG_MAX_RANGE:  range_lim_r  <= cfg_data[15:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // valid bits advance with the data; no stall exists
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], req_w};
  end

  // grid angle: linear formula with saturation, exact limit on the last index
  assign pitch_sum_w = 22'(min_pitch_r)
                       + $signed({2'b00, 20'(in_row) * 20'(pitch_step_r)});
  assign yaw_sum_w   = 24'(min_yaw_r)
                       + $signed({2'b00, 22'(in_column) * 22'(yaw_step_r)});

  always_comb begin
    if (32'(in_row) == 32'(PITCH_ROWS - 1))  pitch_nxt = max_pitch_r;
    else if (pitch_sum_w > 22'sd65535)       pitch_nxt = 17'sd65535;
    else if (pitch_sum_w < -22'sd65536)      pitch_nxt = -17'sd65536;
    else                                     pitch_nxt = 17'(pitch_sum_w);
    if (32'(in_column) == 32'(YAW_COLUMNS - 1)) yaw_nxt = max_yaw_r;
    else if (yaw_sum_w > 24'sd65535)            yaw_nxt = 17'sd65535;
    else if (yaw_sum_w < -24'sd65536)           yaw_nxt = -17'sd65536;
    else                                        yaw_nxt = 17'(yaw_sum_w);
  end

  always_ff @(posedge clk) begin
    pitch_r <= pitch_nxt;
    yaw_r   <= yaw_nxt;
  end

  rep_cordic u_pitch (.clk(clk), .ang(pitch_r), .cos_v(cp_w), .sin_v(sp_w));
  rep_cordic u_yaw   (.clk(clk), .ang(yaw_r),   .cos_v(cy_w), .sin_v(sy_w));

  // direction products, then round half away from zero back to 2^-30
  always_ff @(posedge clk) begin
    pxx_r <= 64'(cp_w) * 64'(cy_w);
    pxy_r <= 64'(cp_w) * 64'(sy_w);
    sp1_r <= sp_w;
  end

  always_ff @(posedge clk) begin
    ux_r <= pxx_r[63] ? 32'(-((-pxx_r + 64'sd536870912) >>> 30))
                      : 32'((pxx_r + 64'sd536870912) >>> 30);
    uy_r <= pxy_r[63] ? 32'(-((-pxy_r + 64'sd536870912) >>> 30))
                      : 32'((pxy_r + 64'sd536870912) >>> 30);
    uz_r <= sp1_r;
  end

  rep_scale u_scale_x (.clk(clk), .v(ux_r), .range(range_lim_r), .end_v(out_end_x));
  rep_scale u_scale_y (.clk(clk), .v(uy_r), .range(range_lim_r), .end_v(out_end_y));
  rep_scale u_scale_z (.clk(clk), .v(uz_r), .range(range_lim_r), .end_v(out_end_z));

  assign out_valid = vld_r[LAT-1];

  a_out_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result strobe without a matching request");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    req_w && (32'(in_row) == 32'(PITCH_ROWS - 1)) |=> pitch_r == $past(max_pitch_r))
    else $error("last row did not take the exact pitch limit");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for the ray end point generator
// Sends scan grid requests under many register settings, predicts the end points
// of untyped rays with a CORDIC model of its own and checks every strobed result.
// ----------------------------------------------------------------------------
module tb import rep_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAST_ROW    = 15;
  localparam int LAST_COL    = 63;
  localparam int SETTLE      = 32;    // pipeline depth plus margin
  localparam int STALL_LIMIT = 4000;  // cycles with no handshake at all
  localparam int RAND_PHASES = 16;
  localparam int PHASE_RAYS  = 100;
  localparam longint ONE30   = 64'sd1 << 30;

  typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } end_pt_t;

  typedef enum int {
    SET_KEEP, SET_ZERO_RANGE, SET_SATURATE, SET_FLIPPED, SET_QUARTERS
  } setting_t;

  typedef struct {
    setting_t           setting;
    logic [3:0]         row;
    logic [5:0]         col;
    bit                 typed;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } ray_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         in_row = '0;
  logic [5:0]         in_column = '0;
  logic               out_valid;
  logic signed [17:0] out_end_x;
  logic signed [17:0] out_end_y;
  logic signed [17:0] out_end_z;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [16:0]        cfg_data = '0;

  // register shadow, kept in step with every accepted write
  logic signed [16:0] sh_min_pitch, sh_max_pitch, sh_min_yaw, sh_max_yaw;
  logic [15:0]        sh_pitch_step, sh_yaw_step, sh_range_lim;

  end_pt_t pending_pts[$];
  int      errors = 0;
  int      rays_sent = 0;
  int      pts_seen = 0;
  int      reg_writes = 0;
  int      idle_cycles = 0;

  ray_endpoint_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_row    (in_row),
    .in_column (in_column),
    .out_valid (out_valid),
    .out_end_x (out_end_x),
    .out_end_y (out_end_y),
    .out_end_z (out_end_z),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // End point predictor
  // ---------------------------------------------------------------------------
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // cos and sin of an angle in 2^-13 rad, both in 2^-30 units
  function automatic void ray_sin_cos(input longint ang, output longint c, output longint s);
    longint hp, a, k, z, x, y, nx;
    hp = longint'(HALF_PI);
    a  = ang * 131072;
    k  = (a + 8 * hp + hp / 2) / hp;
    z  = a - (k - 8) * hp;
    x  = longint'(CORD_GAIN);
    y  = 0;
    for (int i = 0; i < CORD_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    case (k & 3)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // scale one unit vector component by 1.1 * range limit and clamp to 18 bits
  function automatic logic signed [17:0] scale_axis(longint v30);
    longint mag;
    mag = longint'(sh_range_lim) * 11;
    return 18'(clip(round_div(mag * v30, 10 * ONE30), -131072, 131071));
  endfunction

  function automatic end_pt_t predict_end_pt(logic [3:0] row, logic [5:0] col);
    end_pt_t pt;
    longint  pitch, yaw, cp, sp, cy, sy;
    if (row == LAST_ROW) pitch = longint'(sh_max_pitch);
    else pitch = clip(longint'(sh_min_pitch) + longint'(row) * longint'(sh_pitch_step),
                      -65536, 65535);
    if (col == LAST_COL) yaw = longint'(sh_max_yaw);
    else yaw = clip(longint'(sh_min_yaw) + longint'(col) * longint'(sh_yaw_step),
                    -65536, 65535);
    ray_sin_cos(pitch, cp, sp);
    ray_sin_cos(yaw, cy, sy);
    pt.x = scale_axis(round_div(cp * cy, ONE30));
    pt.y = scale_axis(round_div(cp * sy, ONE30));
    pt.z = scale_axis(sp);
    return pt;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest pending end point
  // ---------------------------------------------------------------------------
  task automatic report_miss(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, pts_seen);
  endtask

  always @(posedge clk) begin
    end_pt_t want;
    if (rst_n && out_valid) begin
      if (pending_pts.size() == 0) begin
        report_miss("unexpected result, end_x", out_end_x, 0);
      end else begin
        want = pending_pts.pop_front();
        if (out_end_x !== want.x) report_miss("end_x", out_end_x, want.x);
        if (out_end_y !== want.y) report_miss("end_y", out_end_y, want.y);
        if (out_end_z !== want.z) report_miss("end_z", out_end_z, want.z);
      end
      pts_seen++;
    end
  end

  // Watchdog: count cycles in which no handshake of any kind completes
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: %0d cycles without progress", idle_cycles);
        $display("ray_endpoint_generator regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Hold the write until ready; leave valid high so a following write can chain
  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_PITCH:  sh_min_pitch  = val;
      CFG_PITCH_STEP: sh_pitch_step = val[15:0];
      CFG_MAX_PITCH:  sh_max_pitch  = val;
      CFG_MIN_YAW:    sh_min_yaw    = val;
      CFG_YAW_STEP:   sh_yaw_step   = val[15:0];
      CFG_MAX_YAW:    sh_max_yaw    = val;
      CFG_MAX_RANGE:  sh_range_lim  = val[15:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Wait for every pending end point, then let the pipeline empty out
  task automatic settle();
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_all(int mp, int ps, int xp, int my, int ys, int xy, int rg);
    settle();
    write_reg(CFG_MIN_PITCH,  17'(mp));
    write_reg(CFG_PITCH_STEP, 17'(ps));
    write_reg(CFG_MAX_PITCH,  17'(xp));
    write_reg(CFG_MIN_YAW,    17'(my));
    write_reg(CFG_YAW_STEP,   17'(ys));
    write_reg(CFG_MAX_YAW,    17'(xy));
    write_reg(CFG_MAX_RANGE,  17'(rg));
    cfg_valid <= 1'b0;
    cfg_data  <= 17'($urandom);
  endtask

  task automatic apply_setting(setting_t s);
    case (s)
      SET_ZERO_RANGE: program_all(1000, 300, -5000, -7000, 900, 20000, 0);
      SET_SATURATE:   program_all(65535, 65535, -65536, -65536, 65535, 65535, 65535);
      SET_FLIPPED:    program_all(-65536, 65535, 65535, 65535, 0, -65536, 1);
      SET_QUARTERS:   program_all(-12868, 1715, 12868, -25736, 817, 25736, 65535);
      default: ;
    endcase
  endtask

  // Raise the request and hold it until accepted; idle afterwards at random
  task automatic issue_ray(logic [3:0] row, logic [5:0] col, bit typed, end_pt_t typed_pt,
                           bit no_gaps);
    int gap;
    start     <= 1'b1;
    in_row    <= row;
    in_column <= col;
    do @(posedge clk); while (busy);
    pending_pts.push_back(typed ? typed_pt : predict_end_pt(row, col));
    rays_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start     <= 1'b0;
      in_row    <= 4'($urandom);
      in_column <= 6'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int rand_angle();
    case ($urandom_range(0, 5))
      0: return -65536;
      1: return 65535;
      2: return 0;
      3: return $urandom_range(0, 25736) - 12868;
      default: return $urandom_range(0, 131071) - 65536;
    endcase
  endfunction

  function automatic int rand_step();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 4000);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int rand_range();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(1, 4000);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  ray_req_t dir_tab[] = '{
    // reset defaults: every angle zero, range 10 m, so the ray points along x
    '{SET_KEEP, 4'd0,  6'd0,  1'b1, 18'sd2816, 18'sd0, 18'sd0},
    '{SET_KEEP, 4'd15, 6'd63, 1'b1, 18'sd2816, 18'sd0, 18'sd0},
    '{SET_KEEP, 4'd7,  6'd31, 1'b1, 18'sd2816, 18'sd0, 18'sd0},
    // zero range gives the origin whatever the angles
    '{SET_ZERO_RANGE, 4'd0,  6'd0,  1'b1, 18'sd0, 18'sd0, 18'sd0},
    '{SET_ZERO_RANGE, 4'd15, 6'd63, 1'b1, 18'sd0, 18'sd0, 18'sd0},
    '{SET_ZERO_RANGE, 4'd9,  6'd40, 1'b1, 18'sd0, 18'sd0, 18'sd0},
    // angle sums that saturate, and the exact last row and column
    '{SET_SATURATE, 4'd0,  6'd0,  1'b0, 0, 0, 0},
    '{SET_SATURATE, 4'd1,  6'd1,  1'b0, 0, 0, 0},
    '{SET_SATURATE, 4'd14, 6'd62, 1'b0, 0, 0, 0},
    '{SET_SATURATE, 4'd15, 6'd63, 1'b0, 0, 0, 0},
    '{SET_SATURATE, 4'd15, 6'd0,  1'b0, 0, 0, 0},
    '{SET_SATURATE, 4'd0,  6'd63, 1'b0, 0, 0, 0},
    // negative extremes, smallest nonzero range
    '{SET_FLIPPED, 4'd0,  6'd0,  1'b0, 0, 0, 0},
    '{SET_FLIPPED, 4'd2,  6'd5,  1'b0, 0, 0, 0},
    '{SET_FLIPPED, 4'd15, 6'd63, 1'b0, 0, 0, 0},
    '{SET_FLIPPED, 4'd14, 6'd62, 1'b0, 0, 0, 0},
    // sweep across quarter turns at full range
    '{SET_QUARTERS, 4'd0,  6'd0,  1'b0, 0, 0, 0},
    '{SET_QUARTERS, 4'd3,  6'd10, 1'b0, 0, 0, 0},
    '{SET_QUARTERS, 4'd8,  6'd32, 1'b0, 0, 0, 0},
    '{SET_QUARTERS, 4'd12, 6'd50, 1'b0, 0, 0, 0},
    '{SET_QUARTERS, 4'd15, 6'd63, 1'b0, 0, 0, 0}
  };

  initial begin
    setting_t cur;
    end_pt_t  pt;
    bit       no_gaps;

    // shadow starts at the reset values of the block
    sh_min_pitch = '0; sh_pitch_step = '0; sh_max_pitch = '0;
    sh_min_yaw = '0;   sh_yaw_step = '0;   sh_max_yaw = '0;
    sh_range_lim = 16'd2560;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: program a new setting only when the row asks for one
    cur = SET_KEEP;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].setting != cur) begin
        start <= 1'b0;
        apply_setting(dir_tab[i].setting);
        cur = dir_tab[i].setting;
      end
      pt.x = dir_tab[i].x;
      pt.y = dir_tab[i].y;
      pt.z = dir_tab[i].z;
      issue_ray(dir_tab[i].row, dir_tab[i].col, dir_tab[i].typed, pt, 1'b0);
    end

    // random phases, each with fresh register contents
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      start <= 1'b0;
      program_all(rand_angle(), rand_step(), rand_angle(), rand_angle(), rand_step(),
                  rand_angle(), rand_range());
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_RAYS; n++) begin
        issue_ray(4'($urandom), 6'($urandom), 1'b0, pt, no_gaps);
      end
    end

    start <= 1'b0;
    settle();
    if (pending_pts.size() != 0) begin
      errors++;
      $display("%0d end points never arrived", pending_pts.size());
    end

    $display("sent %0d rays, checked %0d end points, %0d register writes",
             rays_sent, pts_seen, reg_writes);
    $display("covered reset defaults, zero range, saturating sums and random grids");
    if (errors == 0) begin
      $display("ray_endpoint_generator regression: pass");
    end else begin
      $display("ray_endpoint_generator regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/rep_pkg.sv
src/rep_cordic.sv
src/rep_scale.sv
src/ray_endpoint_generator.sv
tb/tb.sv
